[src/shf_pkg.sv]
`default_nettype none

package shf_pkg;

    // Fixed-point layout of the pressure filter.
    localparam int FILTER_FRAC_BITS = 8;
    localparam int ALPHA_BITS       = 16;

    // Field widths.
    localparam int TIME_W  = 32;
    localparam int RAW_W   = 24;
    localparam int CFG_W   = 16;
    localparam int FILT_W  = 32;
    localparam int CIDX_W  = 3;

    // Shifted raw pressure; at least one bit wider than the filter so the
    // saturation test is always meaningful.
    localparam int X_W = (RAW_W + FILTER_FRAC_BITS > FILT_W) ?
                         (RAW_W + FILTER_FRAC_BITS) : (FILT_W + 1);
    // Product of the filter error and the weight, plus a carry bit.
    localparam int PROD_W = FILT_W + CFG_W + 1;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        FUNC_POLL   = 2'd0,
        FUNC_REINIT = 2'd1,
        FUNC_TAKE   = 2'd2,
        FUNC_INVAL  = 2'd3
    } t_func;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_POLL_PERIOD = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_STALE       = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_RECOVER     = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_COOLDOWN    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_ALPHA       = 3'd4;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_POLL_PERIOD = 16'd1000;
    localparam logic [CFG_W-1:0] RST_STALE       = 16'd5000;
    localparam logic [CFG_W-1:0] RST_RECOVER     = 16'd10000;
    localparam logic [CFG_W-1:0] RST_COOLDOWN    = 16'd10000;
    localparam logic [CFG_W-1:0] RST_ALPHA       = 16'd6554;

    typedef struct packed {
        logic [CFG_W-1:0] poll_period_ms;
        logic [CFG_W-1:0] stale_ms;
        logic [CFG_W-1:0] recover_ms;
        logic [CFG_W-1:0] recover_cooldown_ms;
        logic [CFG_W-1:0] filter_alpha;
    } t_cfg;

    typedef struct packed {
        t_func              func;
        logic [TIME_W-1:0]  now_ms;
        logic               read_ok;
        logic [RAW_W-1:0]   raw_temp;
        logic [RAW_W-1:0]   raw_pressure;
        logic               reinit_ok;
    } t_item;

    typedef struct packed {
        logic               reinit_request;
        logic               sample_accepted;
        logic               pressure_valid;
        logic               new_data;
        logic [FILT_W-1:0]  filtered_pressure;
        logic [RAW_W-1:0]   temperature;
        logic               sensor_ready;
    } t_result;

endpackage

`default_nettype wire

[src/sensor_sample_health_filter.sv]
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_func .. i_reinit_ok, one item
// result    out        o_valid / i_ready    o_reinit_request .. o_sensor_ready
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data (16 bits)
//
// An item waits in the input register, where the state update and the
// filter multiply are done, until its result moves into the output register.
// One item per cycle is sustained while the result side is ready.
// Reset is synchronous and clears all state and both stages.
// A stalled result holds in the output register while the input register can
// still take one more item.
`default_nettype none

module sensor_sample_health_filter import shf_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  [1:0]              i_func,
    input  wire  [TIME_W-1:0]       i_now_ms,
    input  wire                     i_read_ok,
    input  wire  signed [RAW_W-1:0] i_raw_temp,
    input  wire  [RAW_W-1:0]        i_raw_pressure,
    input  wire                     i_reinit_ok,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic                    o_reinit_request,
    output logic                    o_sample_accepted,
    output logic                    o_pressure_valid,
    output logic                    o_new_data,
    output logic [FILT_W-1:0]       o_filtered_pressure,
    output logic signed [RAW_W-1:0] o_temperature,
    output logic                    o_sensor_ready,
    input  wire                     i_cfg_we,
    input  wire  [CIDX_W-1:0]       i_cfg_idx,
    input  wire  [CFG_W-1:0]        i_cfg_data
);

    t_cfg    w_cfg;
    t_item   w_in_item;
    t_item   w_item;
    t_result w_core_res;
    t_result w_out_res;
    logic    w_busy;
    logic    w_advance;

    always_comb begin
        w_in_item.func         = t_func'(i_func);
        w_in_item.now_ms       = i_now_ms;
        w_in_item.read_ok      = i_read_ok;
        w_in_item.raw_temp     = i_raw_temp;
        w_in_item.raw_pressure = i_raw_pressure;
        w_in_item.reinit_ok    = i_reinit_ok;
    end

    shf_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    shf_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_busy    (w_busy),
        .o_item    (w_item)
    );

    shf_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_advance),
        .i_item   (w_item),
        .i_cfg    (w_cfg),
        .o_result (w_core_res)
    );

    shf_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_busy    (w_busy),
        .i_result  (w_core_res),
        .i_ready   (i_ready),
        .o_advance (w_advance),
        .o_valid   (o_valid),
        .o_result  (w_out_res)
    );

    assign o_reinit_request    = w_out_res.reinit_request;
    assign o_sample_accepted   = w_out_res.sample_accepted;
    assign o_pressure_valid    = w_out_res.pressure_valid;
    assign o_new_data          = w_out_res.new_data;
    assign o_filtered_pressure = w_out_res.filtered_pressure;
    assign o_temperature       = w_out_res.temperature;
    assign o_sensor_ready      = w_out_res.sensor_ready;

endmodule

`default_nettype wire

[src/shf_cfg_regs.sv]
`default_nettype none

module shf_cfg_regs import shf_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [CIDX_W-1:0] i_cfg_idx,
    input  wire  [CFG_W-1:0]  i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    // Register file; writes to unused indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.poll_period_ms      <= RST_POLL_PERIOD;
            r_cfg.stale_ms            <= RST_STALE;
            r_cfg.recover_ms          <= RST_RECOVER;
            r_cfg.recover_cooldown_ms <= RST_COOLDOWN;
            r_cfg.filter_alpha        <= RST_ALPHA;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POLL_PERIOD: r_cfg.poll_period_ms      <= i_cfg_data;
                CFG_STALE:       r_cfg.stale_ms            <= i_cfg_data;
                CFG_RECOVER:     r_cfg.recover_ms          <= i_cfg_data;
                CFG_COOLDOWN:    r_cfg.recover_cooldown_ms <= i_cfg_data;
                CFG_ALPHA:       r_cfg.filter_alpha        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[src/shf_in_stage.sv]
`default_nettype none

module shf_in_stage import shf_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire    i_valid,
    output logic   o_ready,
    input  t_item  i_item,
    input  wire    i_advance,
    output logic   o_busy,
    output t_item  o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    // The register is free when empty or when its item moves on this cycle.
    assign o_ready = !r_valid || i_advance;
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_busy = r_valid;
    assign o_item = r_item;

endmodule

`default_nettype wire

[src/shf_core.sv]
`default_nettype none

module shf_core import shf_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_en,
    input  t_item    i_item,
    input  t_cfg     i_cfg,
    output t_result  o_result
);

    // Health and filter state.
    logic              r_ready_flag, n_ready_flag;
    logic              r_seeded, n_seeded;
    logic              r_valid_flag, n_valid_flag;
    logic              r_pending, n_pending;
    logic              r_nd_active, n_nd_active;
    logic              r_good_known, n_good_known;
    logic [FILT_W-1:0] r_filter, n_filter;
    logic [RAW_W-1:0]  r_temp, n_temp;
    logic [TIME_W-1:0] r_last_poll, n_last_poll;
    logic [TIME_W-1:0] r_last_good, n_last_good;
    logic [TIME_W-1:0] r_nd_start, n_nd_start;
    logic [TIME_W-1:0] r_last_rec, n_last_rec;

    logic [TIME_W-1:0] w_now;
    logic [TIME_W-1:0] w_nd_start;
    logic              w_cool_ok;
    logic              w_poll_due;
    logic              w_good;
    logic              w_stale;
    logic              w_recover_due;
    logic [X_W-1:0]    w_x_full;
    logic [FILT_W-1:0] w_x;
    logic              w_up;
    logic [FILT_W-1:0] w_mag;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_step_full;
    logic [FILT_W-1:0] w_step;
    logic [FILT_W-1:0] w_filt_upd;
    logic              w_request;
    logic              w_accepted;
    logic              w_nd;

    // Elapsed-time tests, all modulo 2^32.
    assign w_now      = i_item.now_ms;
    assign w_nd_start = r_nd_active ? r_nd_start : w_now;
    assign w_cool_ok  = (w_now - r_last_rec) >= TIME_W'(i_cfg.recover_cooldown_ms);
    assign w_poll_due = (w_now - r_last_poll) >= TIME_W'(i_cfg.poll_period_ms);
    assign w_stale    = r_good_known &&
                        ((w_now - r_last_good) > TIME_W'(i_cfg.stale_ms));
    assign w_recover_due = (w_now - w_nd_start) >= TIME_W'(i_cfg.recover_ms);
    assign w_good     = i_item.read_ok && (i_item.raw_pressure != '0);

    // Filter step: shifted sample, error magnitude, weighted and rounded.
    assign w_x_full = X_W'(i_item.raw_pressure) << FILTER_FRAC_BITS;
    assign w_x      = (w_x_full > X_W'({FILT_W{1'b1}})) ? {FILT_W{1'b1}}
                                                       : w_x_full[FILT_W-1:0];
    assign w_up     = w_x >= r_filter;
    assign w_mag    = w_up ? (w_x - r_filter) : (r_filter - w_x);
    assign w_prod   = PROD_W'(w_mag) * PROD_W'(i_cfg.filter_alpha);
    assign w_step_full = (w_prod + (PROD_W'(1) << (ALPHA_BITS - 1))) >> ALPHA_BITS;
    // The step never overshoots the sample.
    assign w_step   = (w_step_full > PROD_W'(w_mag)) ? w_mag
                                                     : w_step_full[FILT_W-1:0];
    assign w_filt_upd = !r_seeded ? w_x :
                        (w_up ? (r_filter + w_step) : (r_filter - w_step));

    // Next state and the result of the item in the input register.
    always_comb begin
        n_ready_flag = r_ready_flag;
        n_seeded     = r_seeded;
        n_valid_flag = r_valid_flag;
        n_pending    = r_pending;
        n_nd_active  = r_nd_active;
        n_good_known = r_good_known;
        n_filter     = r_filter;
        n_temp       = r_temp;
        n_last_poll  = r_last_poll;
        n_last_good  = r_last_good;
        n_nd_start   = r_nd_start;
        n_last_rec   = r_last_rec;
        w_request    = 1'b0;
        w_accepted   = 1'b0;
        w_nd         = r_pending;

        unique case (i_item.func)
            FUNC_POLL: begin
                if (!r_ready_flag) begin
                    // Not initialized: only a re-init request may be raised.
                    if (w_cool_ok) begin
                        w_request  = 1'b1;
                        n_last_rec = w_now;
                    end
                end else if (w_poll_due) begin
                    n_last_poll = w_now;
                    if (!w_good) begin
                        // Failed read or zero pressure: no-data timing.
                        n_nd_active = 1'b1;
                        n_nd_start  = w_nd_start;
                        if (w_stale) begin
                            n_valid_flag = 1'b0;
                        end
                        if (w_recover_due && w_cool_ok) begin
                            w_request  = 1'b1;
                            n_last_rec = w_now;
                        end
                    end else begin
                        n_temp       = i_item.raw_temp;
                        n_nd_active  = 1'b0;
                        n_filter     = w_filt_upd;
                        n_seeded     = 1'b1;
                        n_last_good  = w_now;
                        n_good_known = 1'b1;
                        n_valid_flag = 1'b1;
                        n_pending    = 1'b1;
                        w_accepted   = 1'b1;
                    end
                end
                w_nd = n_pending;
            end
            FUNC_REINIT: begin
                if (i_item.reinit_ok) begin
                    n_ready_flag = 1'b1;
                    n_valid_flag = 1'b0;
                    n_seeded     = 1'b0;
                    n_pending    = 1'b0;
                    n_nd_active  = 1'b0;
                    n_good_known = 1'b0;
                end else begin
                    n_ready_flag = 1'b0;
                end
                w_nd = n_pending;
            end
            FUNC_TAKE: begin
                w_nd      = r_pending;
                n_pending = 1'b0;
            end
            FUNC_INVAL: begin
                n_valid_flag = 1'b0;
                n_pending    = 1'b0;
                w_nd         = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Control flags, filter value, temperature and timestamps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_flag <= 1'b0;
            r_seeded     <= 1'b0;
            r_valid_flag <= 1'b0;
            r_pending    <= 1'b0;
            r_nd_active  <= 1'b0;
            r_good_known <= 1'b0;
            r_filter     <= '0;
            r_temp       <= '0;
            r_last_poll  <= '0;
            r_last_good  <= '0;
            r_nd_start   <= '0;
            r_last_rec   <= '0;
        end else if (i_en) begin
            r_ready_flag <= n_ready_flag;
            r_seeded     <= n_seeded;
            r_valid_flag <= n_valid_flag;
            r_pending    <= n_pending;
            r_nd_active  <= n_nd_active;
            r_good_known <= n_good_known;
            r_filter     <= n_filter;
            r_temp       <= n_temp;
            r_last_poll  <= n_last_poll;
            r_last_good  <= n_last_good;
            r_nd_start   <= n_nd_start;
            r_last_rec   <= n_last_rec;
        end
    end

    always_comb begin
        o_result.reinit_request    = w_request;
        o_result.sample_accepted   = w_accepted;
        o_result.pressure_valid    = n_valid_flag;
        o_result.new_data          = w_nd;
        o_result.filtered_pressure = n_filter;
        o_result.temperature       = n_temp;
        o_result.sensor_ready      = n_ready_flag;
    end

endmodule

`default_nettype wire

[src/shf_out_stage.sv]
`default_nettype none

module shf_out_stage import shf_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_busy,
    input  t_result  i_result,
    input  wire      i_ready,
    output logic     o_advance,
    output logic     o_valid,
    output t_result  o_result
);

    logic    r_valid;
    t_result r_result;

    // An item leaves the input register when the result register is free.
    assign o_advance = i_busy && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

[src/shf_checker.sv]
`default_nettype none

module shf_checker import shf_pkg::*; (
    input wire                     i_clk,
    input wire                     i_rst_n,
    input wire                     o_ready,
    input wire                     o_valid,
    input wire                     i_ready,
    input wire                     o_reinit_request,
    input wire                     o_sample_accepted,
    input wire                     o_pressure_valid,
    input wire                     o_new_data,
    input wire  [FILT_W-1:0]       o_filtered_pressure,
    input wire  signed [RAW_W-1:0] o_temperature,
    input wire                     o_sensor_ready
);

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_filtered_pressure)
            && $stable(o_temperature) && $stable(o_new_data))
        else $error("stalled result changed");

    // A taken sample leaves the sensor ready with fresh, unread data.
    a_sample_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sample_accepted |->
            o_pressure_valid && o_new_data && o_sensor_ready)
        else $error("accepted sample without fresh pending data");

    // A re-init request comes only from a poll that took no sample.
    a_request_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reinit_request |-> !o_sample_accepted)
        else $error("re-init request together with an accepted sample");

    // While the result stage is empty, the block always has room for input.
    a_no_deadlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked while result stage is empty");

endmodule

bind sensor_sample_health_filter shf_checker u_shf_checker (.*);

`default_nettype wire

[verif/sensor_sample_health_filter_tb.sv]
`timescale 1ns / 1ps

module sensor_sample_health_filter_tb;
    import shf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int REPORT_CAP  = 40;

    // Predicts the result of every transferred item and holds the results
    // still to come, oldest first.
    class health_tracker;
        // Register copies.
        logic [CFG_W-1:0]  period_ms, stale_lim, recover_lim, cooldown_lim, alpha_w;
        // Block state.
        bit                sensor_up, seeded, fresh, unread, gap_open, good_seen;
        logic [FILT_W-1:0] filt_value;
        logic [RAW_W-1:0]  temp_word;
        logic [TIME_W-1:0] t_poll, t_good, t_gap_start, t_request;
        // Set when a poll raises a re-init request, cleared by a re-init outcome.
        bit                request_seen;
        t_result           due_results[$];
        int                items_taken, results_matched, errors, reports;

        function new();
            period_ms    = RST_POLL_PERIOD;
            stale_lim    = RST_STALE;
            recover_lim  = RST_RECOVER;
            cooldown_lim = RST_COOLDOWN;
            alpha_w      = RST_ALPHA;
        endfunction

        function void load_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_POLL_PERIOD: period_ms    = val;
                CFG_STALE:       stale_lim    = val;
                CFG_RECOVER:     recover_lim  = val;
                CFG_COOLDOWN:    cooldown_lim = val;
                CFG_ALPHA:       alpha_w      = val;
                default: ;
            endcase
        endfunction

        // A re-init request is granted only once the cooldown has run out.
        function bit grant_request(logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] since;
            since = now - t_request;
            if (since < TIME_W'(cooldown_lim)) return 1'b0;
            t_request = now;
            return 1'b1;
        endfunction

        // Failed read or zero pressure: track the no-data stretch.
        function bit missing_sample(logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] age, gap;
            if (!gap_open) begin
                gap_open    = 1'b1;
                t_gap_start = now;
            end
            age = now - t_good;
            if (good_seen && age > TIME_W'(stale_lim)) fresh = 1'b0;
            gap = now - t_gap_start;
            if (gap >= TIME_W'(recover_lim)) return grant_request(now);
            return 1'b0;
        endfunction

        // First-order low-pass step, rounded half away from zero.
        function void smooth_pressure(logic [RAW_W-1:0] raw);
            longint unsigned x, mag, step;
            bit up;
            x = 64'(raw) << FILTER_FRAC_BITS;
            if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
            if (!seeded) begin
                filt_value = x[FILT_W-1:0];
                seeded     = 1'b1;
                return;
            end
            up   = x >= 64'(filt_value);
            mag  = up ? x - 64'(filt_value) : 64'(filt_value) - x;
            step = (mag * 64'(alpha_w) + (64'd1 << (ALPHA_BITS - 1))) >> ALPHA_BITS;
            if (step > mag) step = mag;
            filt_value = up ? filt_value + step[FILT_W-1:0] : filt_value - step[FILT_W-1:0];
        endfunction

        // Notes a transferred item and queues the result it must produce.
        function void take_item(t_item it);
            t_result r;
            logic [TIME_W-1:0] since_poll;
            bit req, acc, nd;
            req = 1'b0;
            acc = 1'b0;
            nd  = 1'b0;
            case (it.func)
                FUNC_POLL: begin
                    since_poll = it.now_ms - t_poll;
                    if (!sensor_up) begin
                        req = grant_request(it.now_ms);
                    end else if (since_poll >= TIME_W'(period_ms)) begin
                        t_poll = it.now_ms;
                        if (!it.read_ok || it.raw_pressure == '0) begin
                            req = missing_sample(it.now_ms);
                        end else begin
                            temp_word = it.raw_temp;
                            gap_open  = 1'b0;
                            smooth_pressure(it.raw_pressure);
                            t_good    = it.now_ms;
                            good_seen = 1'b1;
                            fresh     = 1'b1;
                            unread    = 1'b1;
                            acc       = 1'b1;
                        end
                    end
                    nd = unread;
                    if (req) request_seen = 1'b1;
                end
                FUNC_REINIT: begin
                    if (it.reinit_ok) begin
                        sensor_up = 1'b1;
                        fresh     = 1'b0;
                        seeded    = 1'b0;
                        unread    = 1'b0;
                        gap_open  = 1'b0;
                        good_seen = 1'b0;
                    end else begin
                        sensor_up = 1'b0;
                    end
                    nd           = unread;
                    request_seen = 1'b0;
                end
                FUNC_TAKE: begin
                    nd     = unread;
                    unread = 1'b0;
                end
                default: begin
                    fresh  = 1'b0;
                    unread = 1'b0;
                    nd     = 1'b0;
                end
            endcase
            r.reinit_request    = req;
            r.sample_accepted   = acc;
            r.pressure_valid    = fresh;
            r.new_data          = nd;
            r.filtered_pressure = filt_value;
            r.temperature       = temp_word;
            r.sensor_ready      = sensor_up;
            due_results.push_back(r);
            items_taken++;
        endfunction

        function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
            if (want === got) return 1'b1;
            if (reports < REPORT_CAP) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                reports++;
            end
            return 1'b0;
        endfunction

        // Compares a transferred result with the oldest prediction.
        function void match_result(t_result got);
            t_result want;
            bit ok;
            if (due_results.size() == 0) begin
                errors++;
                if (reports < REPORT_CAP) begin
                    $display("%0t: result with none expected, actual %0h", $time, got);
                    reports++;
                end
                return;
            end
            want = due_results.pop_front();
            ok = 1'b1;
            ok &= field_ok("reinit_request", want.reinit_request, got.reinit_request);
            ok &= field_ok("sample_accepted", want.sample_accepted, got.sample_accepted);
            ok &= field_ok("pressure_valid", want.pressure_valid, got.pressure_valid);
            ok &= field_ok("new_data", want.new_data, got.new_data);
            ok &= field_ok("filtered_pressure", want.filtered_pressure,
                           got.filtered_pressure);
            ok &= field_ok("temperature", want.temperature, got.temperature);
            ok &= field_ok("sensor_ready", want.sensor_ready, got.sensor_ready);
            if (!ok) errors++;
            results_matched++;
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [1:0]              i_func = '0;
    logic [TIME_W-1:0]       i_now_ms = '0;
    logic                    i_read_ok = 1'b0;
    logic signed [RAW_W-1:0] i_raw_temp = '0;
    logic [RAW_W-1:0]        i_raw_pressure = '0;
    logic                    i_reinit_ok = 1'b0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic                    o_reinit_request;
    logic                    o_sample_accepted;
    logic                    o_pressure_valid;
    logic                    o_new_data;
    logic [FILT_W-1:0]       o_filtered_pressure;
    logic signed [RAW_W-1:0] o_temperature;
    logic                    o_sensor_ready;
    logic                    i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    health_tracker     book = new();
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                holds_asked = 0;
    int                holds_done = 0;
    int                hold_left = 0;
    int                cycles = 0;
    int                phases_run = 0;
    logic [TIME_W-1:0] clock_ms = '0;
    logic [RAW_W-1:0]  base_press = 24'h180000;

    sensor_sample_health_filter dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_func             (i_func),
        .i_now_ms           (i_now_ms),
        .i_read_ok          (i_read_ok),
        .i_raw_temp         (i_raw_temp),
        .i_raw_pressure     (i_raw_pressure),
        .i_reinit_ok        (i_reinit_ok),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_reinit_request   (o_reinit_request),
        .o_sample_accepted  (o_sample_accepted),
        .o_pressure_valid   (o_pressure_valid),
        .o_new_data         (o_new_data),
        .o_filtered_pressure(o_filtered_pressure),
        .o_temperature      (o_temperature),
        .o_sensor_ready     (o_sensor_ready),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Cycle budget for the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when one is asked for.
    always @(negedge i_clk) begin
        if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check every result transfer.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_valid && i_ready) begin
            got.reinit_request    = o_reinit_request;
            got.sample_accepted   = o_sample_accepted;
            got.pressure_valid    = o_pressure_valid;
            got.new_data          = o_new_data;
            got.filtered_pressure = o_filtered_pressure;
            got.temperature       = o_temperature;
            got.sensor_ready      = o_sensor_ready;
            book.match_result(got);
        end
    end

    function automatic t_item make_item(t_func f, logic [TIME_W-1:0] t, bit rok,
                                        logic [RAW_W-1:0] temp, logic [RAW_W-1:0] press,
                                        bit iok);
        t_item it;
        it.func         = f;
        it.now_ms       = t;
        it.read_ok      = rok;
        it.raw_temp     = temp;
        it.raw_pressure = press;
        it.reinit_ok    = iok;
        return it;
    endfunction

    // Mostly polls at plausible intervals, with re-init answers to requests,
    // takes, invalidates, failed reads and occasional long silences.
    function automatic t_item random_item();
        t_func             f;
        int unsigned       pick, span;
        logic [RAW_W-1:0]  press;
        logic [TIME_W-1:0] t;
        pick = $urandom_range(99);
        if (!book.sensor_up || book.request_seen) begin
            f = (pick < 55) ? FUNC_REINIT : FUNC_POLL;
        end else if (pick < 78) begin
            f = FUNC_POLL;
        end else if (pick < 88) begin
            f = FUNC_TAKE;
        end else if (pick < 93) begin
            f = FUNC_INVAL;
        end else begin
            f = FUNC_REINIT;
        end
        t = $urandom;
        if (f == FUNC_POLL) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                span = 2 * book.period_ms + 8;
                clock_ms += $urandom_range(span, 0);
            end else if (pick < 90) begin
                span = book.stale_lim + book.recover_lim + 16;
                clock_ms += $urandom_range(span, 0);
            end else if (pick < 97) begin
                span = 3 * book.cooldown_lim + 32;
                clock_ms += $urandom_range(span, 0);
            end else begin
                clock_ms = $urandom;
            end
            t = clock_ms;
        end
        // Pressure: near a drifting level, full range, or zero.
        pick = $urandom_range(99);
        if (pick < 5) begin
            press = '0;
        end else if (pick < 40) begin
            press = RAW_W'($urandom);
        end else begin
            if ($urandom_range(49) == 0) base_press = RAW_W'($urandom);
            press = base_press + RAW_W'($urandom_range(4000)) - RAW_W'(2000);
        end
        return make_item(f, t, $urandom_range(99) < 88, RAW_W'($urandom), press,
                         (f == FUNC_REINIT) ? ($urandom_range(9) != 0)
                                            : 1'($urandom_range(1)));
    endfunction

    // Offers one item and returns at the edge where it is transferred.
    task automatic send_item(t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_func         <= it.func;
        i_now_ms       <= it.now_ms;
        i_read_ok      <= it.read_ok;
        i_raw_temp     <= it.raw_temp;
        i_raw_pressure <= it.raw_pressure;
        i_reinit_ok    <= it.reinit_ok;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        book.take_item(it);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (book.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        book.load_reg(idx, val);
    endtask

    // One configuration setting with its own idle pattern and random items.
    task automatic run_phase(logic [CFG_W-1:0] period, logic [CFG_W-1:0] stale,
                             logic [CFG_W-1:0] recover, logic [CFG_W-1:0] cooldown,
                             logic [CFG_W-1:0] alpha, int send_pct, int recv_pct,
                             int count, bit long_hold);
        write_reg(CFG_POLL_PERIOD, period);
        write_reg(CFG_STALE, stale);
        write_reg(CFG_RECOVER, recover);
        write_reg(CFG_COOLDOWN, cooldown);
        write_reg(CFG_ALPHA, alpha);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int k = 0; k < count; k++) begin
            if (long_hold && k == 40) holds_asked++;
            send_item(random_item());
        end
        release_input();
        wait_idle();
        phases_run++;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sequence under the reset configuration.
        send_item(make_item(FUNC_POLL, 32'd0, 1'b1, 24'h000100, 24'h100000, 1'b0));
        send_item(make_item(FUNC_POLL, 32'd10000, 1'b1, 24'h000100, 24'h100000, 1'b0));
        send_item(make_item(FUNC_REINIT, 32'd10000, 1'b0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(FUNC_POLL, 32'd15000, 1'b1, 24'h0, 24'h100000, 1'b0));
        send_item(make_item(FUNC_REINIT, 32'd15000, 1'b0, 24'h0, 24'h0, 1'b1));
        // Take with nothing pending.
        send_item(make_item(FUNC_TAKE, 32'd15000, 1'b0, 24'h0, 24'h0, 1'b0));
        // Seed with full-scale pressure and the largest temperature.
        send_item(make_item(FUNC_POLL, 32'd16000, 1'b1, 24'h7FFFFF, 24'hFFFFFF, 1'b1));
        // Too soon after the last poll.
        send_item(make_item(FUNC_POLL, 32'd16500, 1'b1, 24'h123456, 24'h000010, 1'b0));
        send_item(make_item(FUNC_POLL, 32'd17000, 1'b1, 24'h800000, 24'h000001, 1'b0));
        send_item(make_item(FUNC_TAKE, 32'hFFFFFFFF, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
        send_item(make_item(FUNC_TAKE, 32'd17000, 1'b0, 24'h0, 24'h0, 1'b0));
        // Failed read, then zero pressure, then stale, then recovery request.
        send_item(make_item(FUNC_POLL, 32'd18000, 1'b0, 24'h000200, 24'h200000, 1'b0));
        send_item(make_item(FUNC_POLL, 32'd19000, 1'b1, 24'h000200, 24'h000000, 1'b0));
        send_item(make_item(FUNC_POLL, 32'd23000, 1'b0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(FUNC_POLL, 32'd28000, 1'b0, 24'h0, 24'h0, 1'b0));
        // Recovery time met again, but inside the cooldown.
        send_item(make_item(FUNC_POLL, 32'd29000, 1'b0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(FUNC_REINIT, 32'd29000, 1'b0, 24'h0, 24'h0, 1'b1));
        // Outcome without a request.
        send_item(make_item(FUNC_REINIT, 32'd29000, 1'b0, 24'h0, 24'h0, 1'b1));
        send_item(make_item(FUNC_POLL, 32'd30000, 1'b1, 24'h0ABCDE, 24'h800000, 1'b0));
        send_item(make_item(FUNC_INVAL, 32'd30000, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
        // Small step that exercises rounding.
        send_item(make_item(FUNC_POLL, 32'd31000, 1'b1, 24'h0ABCDF, 24'h800001, 1'b0));
        // Timestamps across the 32-bit wrap.
        send_item(make_item(FUNC_POLL, 32'hFFFFFFFF, 1'b1, 24'h7FFFFF, 24'h7FFFFF, 1'b0));
        send_item(make_item(FUNC_POLL, 32'd999, 1'b1, 24'h800000, 24'h7FFF00, 1'b0));
        send_item(make_item(FUNC_REINIT, 32'd999, 1'b0, 24'h0, 24'h0, 1'b0));
        send_item(make_item(FUNC_INVAL, 32'd999, 1'b0, 24'h0, 24'h0, 1'b0));
        release_input();
        wait_idle();

        // Random phases over several settings, extremes included.
        clock_ms = 32'd5000;
        run_phase(16'd10, 16'd50, 16'd100, 16'd100, 16'd6554, 0, 0, 290, 1'b0);
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 57, 0, 290, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 57, 290, 1'b0);
        clock_ms = 32'hFFFF_F000;
        run_phase(16'd100, 16'd300, 16'd700, 16'd400, 16'd32768, 14, 14, 290, 1'b0);
        run_phase(16'd20, 16'd90, 16'd150, 16'd60, 16'hFFFF, 0, 0, 290, 1'b1);
        run_phase(16'd1, 16'd1, 16'd3, 16'd2, 16'd1, 57, 0, 290, 1'b0);
        run_phase(CFG_W'($urandom_range(200)), CFG_W'($urandom_range(800)),
                  CFG_W'($urandom_range(1500)), CFG_W'($urandom_range(1000)),
                  CFG_W'($urandom), 14, 57, 290, 1'b0);

        $display("Ran %0d items: directed cases, then %0d register settings from zero to full scale,",
                 book.items_taken, phases_run);
        $display("with idle, stall and long hold-off patterns; %0d results compared, %0d bad.",
                 book.results_matched, book.errors);
        if (book.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/shf_pkg.sv
src/shf_cfg_regs.sv
src/shf_in_stage.sv
src/shf_core.sv
src/shf_out_stage.sv
src/sensor_sample_health_filter.sv
src/shf_checker.sv
verif/sensor_sample_health_filter_tb.sv
